@@ rtl/core/fpga_serial_config_loader_defines.svh @@
// assertion macros shared by the loader rtl
// expects clk and rst in the scope of each use
`ifndef FPGA_SERIAL_CONFIG_LOADER_DEFINES_SVH
`define FPGA_SERIAL_CONFIG_LOADER_DEFINES_SVH

// same-cycle implication
`define FSL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/fsl_pkg.sv @@
// types and constants of the slave-serial configuration loader
// no dependencies
package fsl_pkg;

  localparam int TOTAL_W = 24;
  localparam int TICKS_W = 16;
  localparam int WORD_W  = 16;
  localparam int ADDR_W  = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W  = 2;

  localparam logic [TOTAL_W-1:0] TOTAL_BYTES_RESET = 24'd78756;
  localparam logic [TICKS_W-1:0] SETTLE_RESET      = 16'd10;
  localparam logic [TICKS_W-1:0] DONE_WAIT_RESET   = 16'd2;

  // register indexes
  localparam logic [1:0] REG_TOTAL_BYTES = 2'd0;
  localparam logic [1:0] REG_MSB_FIRST   = 2'd1;
  localparam logic [1:0] REG_SETTLE      = 2'd2;
  localparam logic [1:0] REG_DONE_WAIT   = 2'd3;

  // request opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_WORD  = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_PROG     = 4'd1,
    PH_INITLO   = 4'd2,
    PH_INITHI   = 4'd3,
    PH_SETTLE   = 4'd4,
    PH_LOAD     = 4'd5,
    PH_CHECK    = 4'd6,
    PH_DONEWAIT = 4'd7,
    PH_FINISHED = 4'd8,
    PH_ERROR    = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    JOB_STATUS,
    JOB_WORD,
    JOB_FINAL
  } job_kind_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total_bytes;
    logic               byte_msb_first;
    logic [TICKS_W-1:0] settle_ticks;
    logic [TICKS_W-1:0] done_wait_ticks;
  } cfg_t;

  typedef struct packed {
    job_kind_t         kind;
    logic              program_level;
    logic              done_released;
    logic              din_level;
    phase_t            phase;
    logic              rejected;
    logic              msb_first;
    logic [WORD_W-1:0] data_word;
  } job_t;

endpackage

@@ rtl/core/fpga_serial_config_loader.sv @@
// Slave-serial FPGA configuration loader.
// Input stream: opcode in tuser (tick with INIT sample, start, data word),
// INIT level and data word in tdata. Every request gives one or more results
// on the output stream; tlast marks the final result of a request. Each
// result carries the PROGRAM, DONE and DIN levels, a CCLK pulse flag, the
// sequence phase, the CRC error flag and a rejected-word flag.
// The front end updates the sequence state as a request is accepted and
// queues a job; the back end expands jobs into results one per cycle while
// the receiver is ready. A data word in the load phase gives 16 results (one
// per CCLK pulse, from the back-end serializer), the final-clock tick 2,
// anything else 1. A request passes the job queue, then the output register.
// The four-entry job queue keeps requests flowing while the back end works
// through a word or waits on a stalled receiver; tready drops only when the
// queue is full, and a stalled result holds in the output register.
// Reset puts the sequence in idle with PROGRAM, DONE and DIN high and loads
// the register defaults. Registers are written over the APB port.
module fpga_serial_config_loader #(
  parameter int COUNT_WIDTH = 24,
  parameter int WAIT_WIDTH  = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [23:0]               s_tdata,   // init_level, data_word[15:0], zero pad
  input  logic [1:0]                s_tuser,   // opcode
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [15:0]               m_tdata,   // program_level, done_released, din_level,
                                               // clock_pulse, phase[3:0], crc_error,
                                               // rejected, zero pad
  output logic                      m_tlast,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [fsl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import fsl_pkg::*;

  `include "fpga_serial_config_loader_defines.svh"

  cfg_t       cfg;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  job_t       front_job;
  job_t       q_head;
  logic       q_push, q_pop, q_full, q_valid;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.total_bytes     <= TOTAL_BYTES_RESET;
      cfg.byte_msb_first  <= 1'b0;
      cfg.settle_ticks    <= SETTLE_RESET;
      cfg.done_wait_ticks <= DONE_WAIT_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_TOTAL_BYTES: cfg.total_bytes     <= pwdata[TOTAL_W-1:0];
        REG_MSB_FIRST:   cfg.byte_msb_first  <= pwdata[0];
        REG_SETTLE:      cfg.settle_ticks    <= pwdata[TICKS_W-1:0];
        REG_DONE_WAIT:   cfg.done_wait_ticks <= pwdata[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TOTAL_BYTES: prdata = 32'(cfg.total_bytes);
      REG_MSB_FIRST:   prdata = 32'(cfg.byte_msb_first);
      REG_SETTLE:      prdata = 32'(cfg.settle_ticks);
      REG_DONE_WAIT:   prdata = 32'(cfg.done_wait_ticks);
      default:         prdata = '0;
    endcase
  end

  fsl_front #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .WAIT_WIDTH  (WAIT_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .opcode     (s_tuser),
    .init_level (s_tdata[0]),
    .data_word  (s_tdata[16:1]),
    .cfg        (cfg),
    .q_full     (q_full),
    .push       (q_push),
    .job        (front_job)
  );

  fsl_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_job (front_job),
    .full   (q_full),
    .pop    (q_pop),
    .valid  (q_valid),
    .head   (q_head)
  );

  fsl_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .head     (q_head),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // crc flag only in the error phase
  `FSL_ASSERT_SAME(a_crc_phase, m_tvalid && m_tdata[8], m_tdata[7:4] == PH_ERROR, "crc flag outside error phase")
  // a rejected word is a single non-pulse result
  `FSL_ASSERT_SAME(a_rej_single, m_tvalid && m_tdata[9], m_tlast && !m_tdata[3], "rejected result not single")
  // an accepted request always leaves a queued job
  `FSL_ASSERT_NEXT(a_push_queued, s_tvalid && s_tready, q_valid, "accepted request lost")

endmodule

@@ rtl/core/fsl_front.sv @@
// front end: accepts requests, runs the configuration sequence state
// and classifies each request into a job; uses fsl_pkg
module fsl_front #(
  parameter int COUNT_WIDTH = 24,
  parameter int WAIT_WIDTH  = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                opcode,
  input  logic                      init_level,
  input  logic [fsl_pkg::WORD_W-1:0] data_word,
  input  fsl_pkg::cfg_t             cfg,
  input  logic                      q_full,
  output logic                      push,
  output fsl_pkg::job_t             job
);
  import fsl_pkg::*;

  localparam int CMP_W  = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;
  localparam int WCMP_W = (WAIT_WIDTH > TICKS_W) ? WAIT_WIDTH : TICKS_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [WAIT_WIDTH-1:0]  WAIT_MAX  = '1;

  phase_t                  phase, phase_next;
  logic [COUNT_WIDTH-1:0]  bytes_sent, bytes_sent_next;
  logic [WAIT_WIDTH-1:0]   wait_count, wait_count_next;
  logic                    program_reg, program_reg_next;
  logic                    done_reg, done_reg_next;
  logic                    din_reg, din_reg_next;

  logic [TICKS_W-1:0]      wait_limit;
  logic [WAIT_WIDTH-1:0]   wait_inc;
  logic                    wait_over;
  logic [COUNT_WIDTH-1:0]  bytes_inc;
  logic                    reach_cur, reach_inc;
  logic                    word_last_bit;
  job_kind_t               kind;
  logic                    rej;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // one tick of the running wait, saturating
  assign wait_limit = (phase == PH_DONEWAIT) ? cfg.done_wait_ticks : cfg.settle_ticks;
  assign wait_inc   = (wait_count != WAIT_MAX) ? wait_count + WAIT_WIDTH'(1) : wait_count;
  assign wait_over  = (WCMP_W'(wait_inc) >= WCMP_W'(wait_limit)) || (wait_inc == WAIT_MAX);

  assign bytes_inc = (bytes_sent >= COUNT_MAX - COUNT_WIDTH'(1)) ? COUNT_MAX
                   : bytes_sent + COUNT_WIDTH'(2);
  assign reach_cur = (CMP_W'(bytes_sent) >= CMP_W'(cfg.total_bytes)) ||
                     (bytes_sent == COUNT_MAX);
  assign reach_inc = (CMP_W'(bytes_inc) >= CMP_W'(cfg.total_bytes)) ||
                     (bytes_inc == COUNT_MAX);

  // final bit shifted out of a word
  assign word_last_bit = cfg.byte_msb_first ? data_word[8] : data_word[15];

  always_comb begin
    phase_next       = phase;
    bytes_sent_next  = bytes_sent;
    wait_count_next  = wait_count;
    program_reg_next = program_reg;
    done_reg_next    = done_reg;
    din_reg_next     = din_reg;
    kind             = JOB_STATUS;
    rej              = 1'b0;
    case (opcode)
      OP_START: begin
        program_reg_next = 1'b0;
        done_reg_next    = 1'b0;
        din_reg_next     = 1'b1;
        bytes_sent_next  = '0;
        wait_count_next  = '0;
        phase_next       = (cfg.settle_ticks == '0) ? PH_INITLO : PH_PROG;
      end
      OP_WORD: begin
        if (phase != PH_LOAD) begin
          rej = 1'b1;
        end else begin
          kind            = JOB_WORD;
          din_reg_next    = word_last_bit;
          bytes_sent_next = bytes_inc;
          phase_next      = reach_inc ? PH_CHECK : PH_LOAD;
        end
      end
      OP_TICK: begin
        case (phase)
          PH_PROG: begin
            if (wait_over) begin
              wait_count_next = '0;
              phase_next      = PH_INITLO;
            end else begin
              wait_count_next = wait_inc;
            end
          end
          PH_INITLO: begin
            if (!init_level) begin
              program_reg_next = 1'b1;
              phase_next       = PH_INITHI;
            end
          end
          PH_INITHI: begin
            if (init_level) begin
              wait_count_next = '0;
              if (cfg.settle_ticks == '0) begin
                phase_next = reach_cur ? PH_CHECK : PH_LOAD;
              end else begin
                phase_next = PH_SETTLE;
              end
            end
          end
          PH_SETTLE: begin
            if (wait_over) begin
              wait_count_next = '0;
              phase_next      = reach_cur ? PH_CHECK : PH_LOAD;
            end else begin
              wait_count_next = wait_inc;
            end
          end
          PH_CHECK: begin
            if (!init_level) begin
              phase_next = PH_ERROR;
            end else begin
              done_reg_next   = 1'b1;
              wait_count_next = '0;
              if (cfg.done_wait_ticks == '0) begin
                phase_next = PH_FINISHED;
                kind       = JOB_FINAL;
              end else begin
                phase_next = PH_DONEWAIT;
              end
            end
          end
          PH_DONEWAIT: begin
            if (wait_over) begin
              wait_count_next = '0;
              phase_next      = PH_FINISHED;
              kind            = JOB_FINAL;
            end else begin
              wait_count_next = wait_inc;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // word pulses show the load phase; other jobs show the updated state
  always_comb begin
    job.kind          = kind;
    job.program_level = program_reg_next;
    job.done_released = done_reg_next;
    job.din_level     = din_reg_next;
    job.phase         = (kind == JOB_WORD) ? PH_LOAD : phase_next;
    job.rejected      = rej;
    job.msb_first     = cfg.byte_msb_first;
    job.data_word     = data_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bytes_sent  <= '0;
      wait_count  <= '0;
      program_reg <= 1'b1;
      done_reg    <= 1'b1;
      din_reg     <= 1'b1;
    end else if (push) begin
      phase       <= phase_next;
      bytes_sent  <= bytes_sent_next;
      wait_count  <= wait_count_next;
      program_reg <= program_reg_next;
      done_reg    <= done_reg_next;
      din_reg     <= din_reg_next;
    end
  end

endmodule

@@ rtl/core/fsl_queue.sv @@
// short job queue between the front and the back end
// uses fsl_pkg
module fsl_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fsl_pkg::job_t wr_job,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output fsl_pkg::job_t head
);
  import fsl_pkg::*;

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/fsl_back.sv @@
// back end: expands each job into result beats (sixteen din pulses per
// word, two final clocks, or one status beat) behind an output register; uses fsl_pkg
module fsl_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  fsl_pkg::job_t head,
  output logic          pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [15:0]   m_tdata,
  output logic          m_tlast
);
  import fsl_pkg::*;

  job_t        cur;
  logic        busy;
  logic [3:0]  cnt;

  job_t        sel;
  logic [3:0]  k;
  logic [3:0]  sh;
  logic        din;
  logic        pulse;
  logic        fin;
  logic        crc;
  logic        advance;
  logic        have;

  assign sel = busy ? cur : head;
  assign k   = busy ? cnt : 4'd0;
  // msb-first per byte, low byte first
  assign sh  = sel.msb_first ? {k[3], ~k[2:0]} : k;
  assign crc = (sel.phase == PH_ERROR);

  always_comb begin
    case (sel.kind)
      JOB_WORD: begin
        din   = sel.data_word[sh];
        pulse = 1'b1;
        fin   = (k == 4'd15);
      end
      JOB_FINAL: begin
        din   = sel.din_level;
        pulse = 1'b1;
        fin   = (k == 4'd1);
      end
      default: begin
        din   = sel.din_level;
        pulse = 1'b0;
        fin   = 1'b1;
      end
    endcase
  end

  assign advance = !m_tvalid || m_tready;
  assign have    = busy || q_valid;
  assign pop     = advance && !busy && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      busy     <= 1'b0;
      cnt      <= '0;
    end else if (advance) begin
      m_tvalid <= have;
      if (have) begin
        if (fin) begin
          busy <= 1'b0;
        end else begin
          busy <= 1'b1;
          cnt  <= k + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (advance && have) begin
      m_tdata <= {6'b0, sel.rejected, crc, sel.phase, pulse, din,
                  sel.done_released, sel.program_level};
      m_tlast <= fin;
    end
  end

endmodule

@@ bench/fpga_serial_config_loader_test.sv @@
// self-checking bench for fpga_serial_config_loader: drives requests and apb
// register writes, predicts every pin result in its own model of the sequence
// depends on fsl_pkg and the loader rtl only
module fpga_serial_config_loader_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fsl_pkg::*;

  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam logic [23:0] BYTES_MAX   = 24'hFFFFFF;
  localparam logic [15:0] TICKS_MAX   = 16'hFFFF;
  localparam int          STALL_LIMIT = 1000;
  localparam int          SETTLE_CYCLES = 8;

  typedef struct {
    logic   program_level;
    logic   done_released;
    logic   din_level;
    logic   clock_pulse;
    phase_t phase;
    logic   crc_error;
    logic   rejected;
    logic   last;
  } pin_state_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [23:0]         s_tdata = '0;   // init_level, data_word[15:0], zero pad
  logic [1:0]          s_tuser = '0;   // opcode
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [15:0]         m_tdata;        // program_level, done_released, din_level,
                                       // clock_pulse, phase[3:0], crc_error,
                                       // rejected, zero pad
  logic                m_tlast;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // register copies and sequence state of the predictor
  logic [23:0] cfg_total;
  logic        cfg_msb;
  logic [15:0] cfg_settle;
  logic [15:0] cfg_done_wait;
  phase_t      seq_phase;
  logic [23:0] bytes_sent;
  logic [15:0] tick_count;
  logic        pin_program;
  logic        pin_done;
  logic        pin_din;

  pin_state_t  pending_pins[$];
  int          mismatches = 0;
  bit          steady = 1'b0;

  fpga_serial_config_loader dut (.*);

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    // keep the log short when something is badly broken
    if (mismatches <= 200)
      $display("%0t ns %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  function automatic void reset_predictor();
    cfg_total     = TOTAL_BYTES_RESET;
    cfg_msb       = 1'b0;
    cfg_settle    = SETTLE_RESET;
    cfg_done_wait = DONE_WAIT_RESET;
    seq_phase     = PH_IDLE;
    bytes_sent    = '0;
    tick_count    = '0;
    pin_program   = 1'b1;
    pin_done      = 1'b1;
    pin_din       = 1'b1;
  endfunction

  function automatic pin_state_t pin_snapshot(input logic pulse, input logic rej);
    pin_state_t s;
    s.program_level = pin_program;
    s.done_released = pin_done;
    s.din_level     = pin_din;
    s.clock_pulse   = pulse;
    s.phase         = seq_phase;
    s.crc_error     = (seq_phase == PH_ERROR);
    s.rejected      = rej;
    s.last          = 1'b0;
    return s;
  endfunction

  // one tick of a wait, saturating; true when the wait is over
  function automatic logic wait_elapsed(input logic [15:0] limit);
    if (tick_count != TICKS_MAX)
      tick_count++;
    if (tick_count >= limit || tick_count == TICKS_MAX) begin
      tick_count = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void enter_load();
    seq_phase = PH_LOAD;
    if (bytes_sent >= cfg_total || bytes_sent == BYTES_MAX)
      seq_phase = PH_CHECK;
  endfunction

  task automatic predict_pins(input logic [1:0] op, input logic init, input logic [15:0] word);
    pin_state_t outs[16];
    int         n;
    int         shift;
    logic       finished_now;
    n = 0;
    finished_now = 1'b0;
    case (op)
      OP_START: begin
        pin_program = 1'b0;
        pin_done    = 1'b0;
        pin_din     = 1'b1;
        bytes_sent  = '0;
        tick_count  = '0;
        seq_phase   = (cfg_settle == 0) ? PH_INITLO : PH_PROG;
        outs[0] = pin_snapshot(1'b0, 1'b0);
        n = 1;
      end
      OP_WORD: begin
        if (seq_phase != PH_LOAD) begin
          outs[0] = pin_snapshot(1'b0, 1'b1);
          n = 1;
        end else begin
          for (int k = 0; k < 16; k++) begin
            // byte mode: low byte then high byte, each from its top bit
            if (cfg_msb)
              shift = (k < 8) ? 7 - k : 23 - k;
            else
              shift = k;
            pin_din = word[shift];
            outs[k] = pin_snapshot(1'b1, 1'b0);
          end
          n = 16;
          bytes_sent = (bytes_sent >= BYTES_MAX - 1) ? BYTES_MAX : bytes_sent + 24'd2;
          enter_load();
        end
      end
      OP_TICK: begin
        case (seq_phase)
          PH_PROG: begin
            if (wait_elapsed(cfg_settle))
              seq_phase = PH_INITLO;
          end
          PH_INITLO: begin
            if (!init) begin
              pin_program = 1'b1;
              seq_phase = PH_INITHI;
            end
          end
          PH_INITHI: begin
            if (init) begin
              tick_count = '0;
              if (cfg_settle == 0)
                enter_load();
              else
                seq_phase = PH_SETTLE;
            end
          end
          PH_SETTLE: begin
            if (wait_elapsed(cfg_settle))
              enter_load();
          end
          PH_CHECK: begin
            if (!init) begin
              seq_phase = PH_ERROR;
            end else begin
              pin_done = 1'b1;
              tick_count = '0;
              if (cfg_done_wait == 0) begin
                seq_phase = PH_FINISHED;
                finished_now = 1'b1;
              end else begin
                seq_phase = PH_DONEWAIT;
              end
            end
          end
          PH_DONEWAIT: begin
            if (wait_elapsed(cfg_done_wait)) begin
              seq_phase = PH_FINISHED;
              finished_now = 1'b1;
            end
          end
          default: ;
        endcase
        if (finished_now) begin
          // two closing cclk pulses, din held
          outs[0] = pin_snapshot(1'b1, 1'b0);
          outs[1] = pin_snapshot(1'b1, 1'b0);
          n = 2;
        end else begin
          outs[0] = pin_snapshot(1'b0, 1'b0);
          n = 1;
        end
      end
      default: begin
        outs[0] = pin_snapshot(1'b0, 1'b0);
        n = 1;
      end
    endcase
    outs[n-1].last = 1'b1;
    for (int i = 0; i < n; i++)
      pending_pins.push_back(outs[i]);
  endtask

  task automatic send_request(input logic [1:0] op, input logic init, input logic [15:0] word);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      @(negedge clk) s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, word, init};
    do @(posedge clk); while (!s_tready);
    predict_pins(op, init, word);
  endtask

  task automatic drain_results();
    @(negedge clk) s_tvalid <= 1'b0;
    while (pending_pins.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] index, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(negedge clk) penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_loader(input logic [23:0] total, input logic msb,
                            input logic [15:0] settle, input logic [15:0] done_wait);
    drain_results();
    apb_write(REG_TOTAL_BYTES, {8'd0, total});
    apb_write(REG_MSB_FIRST, {31'd0, msb});
    apb_write(REG_SETTLE, {16'd0, settle});
    apb_write(REG_DONE_WAIT, {16'd0, done_wait});
    cfg_total     = total;
    cfg_msb       = msb;
    cfg_settle    = settle;
    cfg_done_wait = done_wait;
  endtask

  // full load with lsb-first words, init glitches and a done wait
  task automatic test_lsb_first_load();
    set_loader(24'd4, 1'b0, 16'd1, 16'd1);
    send_request(OP_START, 1'b0, 16'h0000);
    send_request(OP_TICK, 1'b1, 16'h0000);
    send_request(OP_TICK, 1'b1, 16'h0000);
    send_request(OP_TICK, 1'b0, 16'h0000);
    send_request(OP_TICK, 1'b1, 16'h0000);
    send_request(OP_TICK, 1'b0, 16'h0000);
    send_request(OP_TICK, 1'b1, 16'h0000);
    send_request(OP_WORD, 1'b0, 16'h8001);
    send_request(OP_WORD, 1'b1, 16'hA5C3);
    send_request(OP_TICK, 1'b1, 16'h0000);
    send_request(OP_TICK, 1'b1, 16'h0000);
    send_request(OP_WORD, 1'b0, 16'h1234);
    send_request(OP_UNUSED, 1'b1, 16'hFFFF);
  endtask

  // byte-wise msb order, zero settle, odd length, init low at the check
  task automatic test_msb_first_crc_error();
    set_loader(24'd3, 1'b1, 16'd0, 16'd0);
    send_request(OP_START, 1'b1, 16'h0000);
    send_request(OP_TICK, 1'b0, 16'h0000);
    send_request(OP_TICK, 1'b1, 16'h0000);
    send_request(OP_WORD, 1'b0, 16'h12F0);
    send_request(OP_WORD, 1'b0, 16'hFFFF);
    send_request(OP_TICK, 1'b0, 16'h0000);
    send_request(OP_TICK, 1'b1, 16'h0000);
    send_request(OP_START, 1'b0, 16'h0000);
  endtask

  // zero byte count goes straight to the check, zero done wait
  task automatic test_zero_length();
    set_loader(24'd0, 1'b0, 16'd0, 16'd0);
    send_request(OP_START, 1'b0, 16'h0000);
    send_request(OP_TICK, 1'b0, 16'h0000);
    send_request(OP_TICK, 1'b1, 16'h0000);
    send_request(OP_WORD, 1'b1, 16'h5A5A);
    send_request(OP_TICK, 1'b1, 16'h0000);
  endtask

  task automatic test_register_extremes();
    set_loader(BYTES_MAX, 1'b1, TICKS_MAX, TICKS_MAX);
    send_request(OP_START, 1'b0, 16'h0000);
    send_request(OP_TICK, 1'b0, 16'h0000);
    send_request(OP_START, 1'b1, 16'h0000);
    set_loader(BYTES_MAX, 1'b0, 16'd0, TICKS_MAX);
    send_request(OP_START, 1'b0, 16'h0000);
    send_request(OP_TICK, 1'b0, 16'h0000);
    send_request(OP_TICK, 1'b1, 16'h0000);
    send_request(OP_WORD, 1'b0, 16'hFFFF);
    send_request(OP_TICK, 1'b0, 16'h0000);
  endtask

  // mostly the request the sequence is waiting for, some random noise
  task automatic send_shaped();
    logic [1:0]  op;
    logic        init;
    logic [15:0] word;
    word = 16'($urandom_range(0, 16'hFFFF));
    init = 1'($urandom_range(0, 1));
    op   = OP_TICK;
    if ($urandom_range(0, 99) < 12) begin
      op = 2'($urandom_range(0, 3));
    end else begin
      case (seq_phase)
        PH_IDLE, PH_FINISHED, PH_ERROR: op = OP_START;
        PH_LOAD: op = OP_WORD;
        PH_INITLO: init = ($urandom_range(0, 3) == 0);
        PH_INITHI, PH_CHECK: init = ($urandom_range(0, 4) != 0);
        default: ;
      endcase
    end
    send_request(op, init, word);
  endtask

  task automatic test_random_sequences();
    logic [23:0] total;
    logic [15:0] settle;
    logic [15:0] done_wait;
    for (int p = 0; p < 8; p++) begin
      total     = (p == 3) ? 24'd0 : 24'($urandom_range(2, 18));
      settle    = (p % 4 == 1) ? 16'd0 : 16'($urandom_range(0, 4));
      done_wait = (p % 4 == 2) ? 16'd0 : 16'($urandom_range(0, 3));
      set_loader(total, 1'($urandom_range(0, 1)), settle, done_wait);
      steady = (p % 3 == 2);
      repeat (37) send_shaped();
    end
    steady = 1'b0;
  endtask

  // receiver with random back-pressure
  initial begin
    int stall;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 15);
      repeat (stall) @(negedge clk) m_tready <= 1'b0;
      @(negedge clk) m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin : check_results
    pin_state_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pins.size() == 0) begin
        report_mismatch("result with nothing expected", m_tdata, 0);
      end else begin
        want = pending_pins.pop_front();
        if (m_tdata[0] !== want.program_level)
          report_mismatch("program_level", m_tdata[0], want.program_level);
        if (m_tdata[1] !== want.done_released)
          report_mismatch("done_released", m_tdata[1], want.done_released);
        if (m_tdata[2] !== want.din_level)
          report_mismatch("din_level", m_tdata[2], want.din_level);
        if (m_tdata[3] !== want.clock_pulse)
          report_mismatch("clock_pulse", m_tdata[3], want.clock_pulse);
        if (m_tdata[7:4] !== want.phase)
          report_mismatch("phase", m_tdata[7:4], want.phase);
        if (m_tdata[8] !== want.crc_error)
          report_mismatch("crc_error", m_tdata[8], want.crc_error);
        if (m_tdata[9] !== want.rejected)
          report_mismatch("rejected", m_tdata[9], want.rejected);
        if (m_tlast !== want.last)
          report_mismatch("last", m_tlast, want.last);
      end
    end
  end

  // ends the run when neither stream moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("fpga_serial_config_loader: mismatch");
    $finish;
  end

  initial begin
    reset_predictor();
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_lsb_first_load();
    test_msb_first_crc_error();
    test_zero_length();
    test_register_extremes();
    test_random_sequences();
    drain_results();
    if (pending_pins.size() != 0)
      report_mismatch("results never arrived", 0, pending_pins.size());
    if (mismatches == 0) begin
      $display("fpga_serial_config_loader: match");
    end else begin
      $display("fpga_serial_config_loader: mismatch");
    end
    $finish;
  end

endmodule
